// ----- rtl/swsfr_pkg.sv -----
// Package with shared types, codes and defaults of the sliding-window sender.
`timescale 1ns / 1ps

package swsfr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEFAULT_MAX_SEQ      = 8;
  localparam int DEFAULT_PAYLOAD_BITS = 64;

  // Width used for all window arithmetic; the sequence space register is 4 bits,
  // so sums of a base and a window always fit.
  localparam int CALC_W = 5;

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_WINDOW = 1'b0;
  localparam logic CFG_IDX_SPACE  = 1'b1;
  localparam logic [2:0] WINDOW_RESET = 3'd4;
  localparam logic [3:0] SPACE_RESET  = 4'd8;

  // Item kinds.
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Timer commands.
  localparam logic [1:0] TIMER_NONE    = 2'd0;
  localparam logic [1:0] TIMER_START   = 2'd1;
  localparam logic [1:0] TIMER_STOP    = 2'd2;
  localparam logic [1:0] TIMER_RESTART = 2'd3;

  // Acknowledgement status codes.
  localparam logic [2:0] ACK_NONE    = 3'd0;
  localparam logic [2:0] ACK_CORRUPT = 3'd1;
  localparam logic [2:0] ACK_NEW     = 3'd2;
  localparam logic [2:0] ACK_DUP     = 3'd3;
  localparam logic [2:0] ACK_FAST    = 3'd4;

  // Duplicate counter wraps modulo DUP_WRAP and resends at DUP_RESEND.
  localparam logic [1:0] DUP_WRAP   = 2'd3;
  localparam logic [1:0] DUP_RESEND = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] payload;
    logic [2:0]  ack_number;
    logic        ack_intact;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic        accepted;
    logic        transmit;
    logic [2:0]  tx_seq;
    logic [63:0] tx_payload;
    logic [1:0]  timer_cmd;
    logic [2:0]  ack_status;
    logic [2:0]  window_base;
    logic [2:0]  next_number;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic eval;
  } ctrl_cmd_t;

endpackage

// ----- rtl/sliding_window_sender_fast_retx.sv -----
// Top level of the sliding-window sender with fast retransmit.
//
//   Channel   Direction  Handshake             Contents
//   in_*      input      in_valid / in_stall   send, ack or timeout item
//   out_*     output     out_valid / out_stall one result per item
//   APB       input      psel/penable/pwrite   window_size at 0x0, seq_space at 0x4
//
// An item is evaluated in the cycle after it is accepted and its result is
// registered at the end of that cycle, then offered from the result register;
// the input is stalled during the evaluate step, so a new item is taken only
// once the last one has been evaluated.
// A new item is taken while a result waits; a second one waits for out_stall
// to drop. Reset clears the window pointers and the duplicate count; the
// packet store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sliding_window_sender_fast_retx #(
  parameter int MAX_SEQ      = swsfr_pkg::DEFAULT_MAX_SEQ,
  parameter int PAYLOAD_BITS = swsfr_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  swsfr_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output swsfr_pkg::out_item_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swsfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  swsfr_pkg::ctrl_cmd_t cmd;
  logic [2:0] window_size_r;
  logic [3:0] seq_space_r;
  logic       cfg_wr;
  logic       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swsfr_pkg::WINDOW_RESET;
      seq_space_r   <= swsfr_pkg::SPACE_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == swsfr_pkg::CFG_IDX_WINDOW) window_size_r <= pwdata[2:0];
      else seq_space_r <= pwdata[3:0];
    end
  end

  // Register readback.
  always_comb begin
    if (cfg_idx == swsfr_pkg::CFG_IDX_SPACE) prdata = 32'(seq_space_r);
    else prdata = 32'(window_size_r);
  end

  swsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  swsfr_dp #(
    .MAX_SEQ      (MAX_SEQ),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .window_size (window_size_r),
    .seq_space   (seq_space_r),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/swsfr_ctrl.sv -----
// Controller state machine that sequences accept, evaluate and result delivery.
`timescale 1ns / 1ps

module swsfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swsfr_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OUT,
    ST_PEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, out_valid_r;
  logic   accept, taken;

  assign accept = in_valid & ~in_stall_r;
  assign taken  = out_valid_r & ~out_stall;

  // Next state: a new item may be taken while a result waits in the output register.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (accept && taken) state_nxt = ST_EVAL;
        else if (accept) state_nxt = ST_PEND;
        else if (taken) state_nxt = ST_IDLE;
      end
      ST_PEND: begin
        if (taken) state_nxt = ST_EVAL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt == ST_EVAL) || (state_nxt == ST_PEND);
      out_valid_r <= (state_nxt == ST_OUT) || (state_nxt == ST_PEND);
    end
  end

  assign in_stall      = in_stall_r;
  assign out_valid     = out_valid_r;
  assign cmd.load_item = accept;
  assign cmd.eval      = (state_r == ST_EVAL);

endmodule

// ----- rtl/swsfr_dp.sv -----
// Datapath with window state, packet store and result registers.
`timescale 1ns / 1ps

module swsfr_dp #(
  parameter int MAX_SEQ      = swsfr_pkg::DEFAULT_MAX_SEQ,
  parameter int PAYLOAD_BITS = swsfr_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swsfr_pkg::ctrl_cmd_t cmd,
  input  swsfr_pkg::in_item_t  in_data,
  input  logic [2:0]           window_size,
  input  logic [3:0]           seq_space,
  output swsfr_pkg::out_item_t out_data
);

  localparam int CW      = swsfr_pkg::CALC_W;
  // The 4-bit sequence space register caps the usable space at 15.
  localparam int EFF_MAX = (MAX_SEQ < 15) ? MAX_SEQ : 15;
  localparam int SEQ_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

  function automatic logic [CW-1:0] wrap_seq(input logic [CW-1:0] v,
                                             input logic [CW-1:0] s);
    return (v >= s) ? v - s : v;
  endfunction

  swsfr_pkg::in_item_t  item_r;
  swsfr_pkg::out_item_t res_r, res_nxt;
  logic [SEQ_W-1:0]        base_seq_r, base_seq_nxt;
  logic [SEQ_W-1:0]        next_seq_r, next_seq_nxt;
  logic [1:0]              dup_count_r, dup_count_nxt;
  logic [PAYLOAD_BITS-1:0] store_mem [EFF_MAX];
  logic [PAYLOAD_BITS-1:0] rd_r;
  logic                    use_rd_r, use_rd_nxt;
  logic                    mem_we;

  logic [CW-1:0] s, w, base_c, next_c, ack_c, win_end, dup_wrap_c;
  logic          full, in_win;

  // Item register, loaded on each input transaction.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  // Effective sequence space and window after clamping.
  always_comb begin
    if (seq_space < 4'd2) s = CW'(2);
    else if (seq_space > 4'(EFF_MAX)) s = CW'(EFF_MAX);
    else s = CW'(seq_space);

    if (window_size == 3'd0) w = CW'(1);
    else if (CW'(window_size) >= s) w = s - CW'(1);
    else w = CW'(window_size);
  end

  // Window end, full test and membership of the acknowledged number.
  always_comb begin
    base_c     = CW'(base_seq_r);
    next_c     = CW'(next_seq_r);
    ack_c      = CW'(item_r.ack_number);
    win_end    = wrap_seq(base_c + w, s);
    full       = (win_end == wrap_seq(next_c, s));
    dup_wrap_c = CW'(dup_count_r) + CW'(1);
    if (ack_c >= s) in_win = 1'b0;
    else if (base_c < win_end) in_win = (ack_c >= base_c) && (ack_c < win_end);
    else in_win = (ack_c >= base_c) || (ack_c < win_end);
  end

  // Decision for one item.
  always_comb begin
    res_nxt       = '0;
    base_seq_nxt  = base_seq_r;
    next_seq_nxt  = next_seq_r;
    dup_count_nxt = dup_count_r;
    use_rd_nxt    = 1'b0;
    mem_we        = 1'b0;
    unique case (item_r.kind)
      swsfr_pkg::KIND_SEND: begin
        if (!full) begin
          mem_we              = cmd.eval;
          res_nxt.accepted    = 1'b1;
          res_nxt.transmit    = 1'b1;
          res_nxt.tx_seq      = 3'(next_seq_r);
          res_nxt.tx_payload  = 64'(item_r.payload[PAYLOAD_BITS-1:0]);
          res_nxt.timer_cmd   = (base_seq_r == next_seq_r) ? swsfr_pkg::TIMER_START
                                                           : swsfr_pkg::TIMER_NONE;
          next_seq_nxt        = SEQ_W'(wrap_seq(next_c + CW'(1), s));
        end
      end
      swsfr_pkg::KIND_ACK: begin
        if (!item_r.ack_intact) begin
          res_nxt.ack_status = swsfr_pkg::ACK_CORRUPT;
        end else if (in_win) begin
          base_seq_nxt       = SEQ_W'(wrap_seq(ack_c + CW'(1), s));
          res_nxt.timer_cmd  = (base_seq_nxt != next_seq_r) ? swsfr_pkg::TIMER_RESTART
                                                            : swsfr_pkg::TIMER_STOP;
          dup_count_nxt      = 2'd0;
          res_nxt.ack_status = swsfr_pkg::ACK_NEW;
        end else begin
          dup_count_nxt = (dup_wrap_c == CW'(swsfr_pkg::DUP_WRAP)) ? 2'd0
                                                                  : 2'(dup_wrap_c);
          if (dup_count_nxt == swsfr_pkg::DUP_RESEND) begin
            res_nxt.transmit   = 1'b1;
            res_nxt.tx_seq     = 3'(base_seq_r);
            use_rd_nxt         = 1'b1;
            res_nxt.ack_status = swsfr_pkg::ACK_FAST;
          end else begin
            res_nxt.ack_status = swsfr_pkg::ACK_DUP;
          end
        end
      end
      swsfr_pkg::KIND_TIMEOUT: begin
        res_nxt.transmit  = 1'b1;
        res_nxt.tx_seq    = 3'(base_seq_r);
        use_rd_nxt        = 1'b1;
        res_nxt.timer_cmd = swsfr_pkg::TIMER_RESTART;
      end
      default: begin
      end
    endcase
    res_nxt.window_base = 3'(base_seq_nxt);
    res_nxt.next_number = 3'(next_seq_nxt);
  end

  // Window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seq_r  <= '0;
      next_seq_r  <= '0;
      dup_count_r <= '0;
    end else if (cmd.eval) begin
      base_seq_r  <= base_seq_nxt;
      next_seq_r  <= next_seq_nxt;
      dup_count_r <= dup_count_nxt;
    end
  end

  // Packet store: write at the next sequence number, registered read at the base.
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[next_seq_r] <= item_r.payload[PAYLOAD_BITS-1:0];
    if (cmd.eval) rd_r <= store_mem[base_seq_r];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_r    <= res_nxt;
      use_rd_r <= use_rd_nxt;
    end
  end

  // Resends take their payload from the store read.
  always_comb begin
    out_data = res_r;
    if (use_rd_r) out_data.tx_payload = 64'(rd_r);
  end

endmodule

// ----- tb/swsfr_tx_monitor.sv -----
// Result monitor for the sliding-window sender: tracks the window, predicts and compares.
`timescale 1ns / 1ps

module swsfr_tx_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  swsfr_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  swsfr_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [swsfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output int                               pending_results,
  output int                               mismatch_count
);
  import swsfr_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = {CFG_IDX_WINDOW, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPACE  = {CFG_IDX_SPACE, 2'b00};
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the registers and of the sender state.
  logic [2:0]  window_reg;
  logic [3:0]  space_reg;
  logic [2:0]  base_q;
  logic [2:0]  next_q;
  logic [1:0]  dup_q;
  logic [63:0] sent_payloads [DEFAULT_MAX_SEQ];

  // Predicted reports, oldest first.
  out_item_t tx_reports_due [$];
  int        faults;

  function automatic int unsigned seq_wrap(input int unsigned v, input int unsigned s);
    return (v >= s) ? v - s : v;
  endfunction

  // Applies one transaction to the shadow state and returns the report it causes.
  function automatic out_item_t advance_window(input in_item_t item);
    out_item_t   rep;
    int unsigned s;
    int unsigned w;
    int unsigned b;
    int unsigned n;
    int unsigned ack;
    int unsigned lim;
    int unsigned dup;
    logic        hit;

    s = (space_reg < 2) ? 2 : (space_reg > DEFAULT_MAX_SEQ) ? DEFAULT_MAX_SEQ : space_reg;
    w = (window_reg == 0) ? 1 : (window_reg >= s) ? s - 1 : window_reg;
    b = base_q;
    n = next_q;
    rep = '0;

    case (item.kind)
      KIND_SEND: begin
        // A full window refuses the send and leaves everything alone.
        if (seq_wrap(b + w, s) != seq_wrap(n, s)) begin
          sent_payloads[n] = item.payload;
          rep.accepted   = 1'b1;
          rep.transmit   = 1'b1;
          rep.tx_seq     = n[2:0];
          rep.tx_payload = item.payload;
          if (b == n) rep.timer_cmd = TIMER_START;
          n = seq_wrap(n + 1, s);
        end
      end
      KIND_ACK: begin
        ack = item.ack_number;
        lim = seq_wrap(b + w, s);
        if (ack >= s) hit = 1'b0;
        else if (b < lim) hit = (ack >= b) && (ack < lim);
        else hit = (ack >= b) || (ack < lim);

        if (!item.ack_intact) begin
          rep.ack_status = ACK_CORRUPT;
        end else if (hit) begin
          b = seq_wrap(ack + 1, s);
          rep.timer_cmd  = (b != n) ? TIMER_RESTART : TIMER_STOP;
          rep.ack_status = ACK_NEW;
          dup_q = '0;
        end else begin
          // Duplicates count modulo the wrap value; the resend point resends the base.
          dup = (dup_q + 1) % DUP_WRAP;
          dup_q = dup[1:0];
          if (dup_q == DUP_RESEND) begin
            rep.transmit   = 1'b1;
            rep.tx_seq     = b[2:0];
            rep.tx_payload = sent_payloads[b];
            rep.ack_status = ACK_FAST;
          end else begin
            rep.ack_status = ACK_DUP;
          end
        end
      end
      KIND_TIMEOUT: begin
        rep.transmit   = 1'b1;
        rep.tx_seq     = b[2:0];
        rep.tx_payload = sent_payloads[b];
        rep.timer_cmd  = TIMER_RESTART;
      end
      default: ;
    endcase

    base_q = b[2:0];
    next_q = n[2:0];
    rep.window_base = base_q;
    rep.next_number = next_q;
    return rep;
  endfunction

  task automatic report_fault(input string what, input logic has_want, input out_item_t want,
                              input out_item_t got);
    faults++;
    if (faults <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, what);
      if (has_want)
        $display("  expected acc=%0d tx=%0d seq=%0d data=%h timer=%0d ack=%0d base=%0d next=%0d",
                 want.accepted, want.transmit, want.tx_seq, want.tx_payload, want.timer_cmd,
                 want.ack_status, want.window_base, want.next_number);
      $display("  actual   acc=%0d tx=%0d seq=%0d data=%h timer=%0d ack=%0d base=%0d next=%0d",
               got.accepted, got.transmit, got.tx_seq, got.tx_payload, got.timer_cmd,
               got.ack_status, got.window_base, got.next_number);
    end
  endtask

  // Watch the register port and both channels once per clock.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      window_reg = WINDOW_RESET;
      space_reg  = SPACE_RESET;
      base_q     = '0;
      next_q     = '0;
      dup_q      = '0;
      faults     = 0;
      tx_reports_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_WINDOW) window_reg = pwdata[2:0];
        else if (paddr == ADDR_SPACE) space_reg = pwdata[3:0];
      end

      // A report leaving now belongs to an earlier transaction, so compare first.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (tx_reports_due.size() == 0) begin
          report_fault("result with no transaction outstanding", 1'b0, '0, got);
        end else begin
          want = tx_reports_due.pop_front();
          if (got.accepted    !== want.accepted    || got.transmit   !== want.transmit   ||
              got.tx_seq      !== want.tx_seq      || got.tx_payload !== want.tx_payload ||
              got.timer_cmd   !== want.timer_cmd   || got.ack_status !== want.ack_status ||
              got.window_base !== want.window_base || got.next_number !== want.next_number)
            report_fault("result mismatch", 1'b1, want, got);
        end
      end

      if (in_valid && !in_stall) tx_reports_due.push_back(advance_window(in_data));
    end
    pending_results <= tx_reports_due.size();
    mismatch_count  <= faults;
  end

endmodule

// ----- tb/sliding_window_sender_fast_retx_tb.sv -----
// Testbench top for the sliding-window sender: stimulus, register setup, stalls and verdict.
`timescale 1ns / 1ps

module sliding_window_sender_fast_retx_tb;
  import swsfr_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = {CFG_IDX_WINDOW, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPACE  = {CFG_IDX_SPACE, 2'b00};
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic hold_req     = 1'b0;
  logic hold_taken   = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   pending_results;
  int   mismatch_count;

  // Register settings and idle patterns of the random phases.
  int phase_window [NUM_PHASES] = '{7, 1, 0, 3, 7, 2, 6, 5, 4};
  int phase_space  [NUM_PHASES] = '{8, 2, 0, 5, 15, 3, 7, 9, 8};
  int phase_idle   [NUM_PHASES] = '{0, 57, 0, 25, 0, 57, 0, 25, 0};
  int phase_stall  [NUM_PHASES] = '{0, 0, 57, 25, 0, 0, 57, 25, 0};

  sliding_window_sender_fast_retx uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  swsfr_tx_monitor monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: one long hold-off when asked, otherwise random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] kind, input logic [63:0] payload,
                                         input logic [2:0] ack, input logic intact);
    in_item_t it;
    it.kind       = kind;
    it.payload    = payload;
    it.ack_number = ack;
    it.ack_intact = intact;
    return it;
  endfunction

  // Mostly sends and acks near the live sequence space, some timeouts and noise.
  function automatic in_item_t random_item(input int unsigned ack_top);
    in_item_t    it;
    int unsigned pick;
    it = make_item(KIND_SEND, {$urandom, $urandom}, 3'($urandom_range(0, 7)), 1'b1);
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 85) begin
      it.kind = KIND_ACK;
      if ($urandom_range(0, 3) != 0) it.ack_number = 3'($urandom_range(0, ack_top));
      if ($urandom_range(0, 9) == 0) it.ack_intact = 1'b0;
    end else if (pick >= 85 && pick < 95) begin
      it.kind = KIND_TIMEOUT;
    end else if (pick >= 95) begin
      it.kind = KIND_UNKNOWN;
      it.ack_intact = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {$urandom} & 32'hFFFF_FFF0 | {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic offer(input in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted report has come back, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned ack_top;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fill every slot of the store before any resend can read one.
    write_reg(ADDR_WINDOW, 4'd7);
    write_reg(ADDR_SPACE, 4'd8);
    offer(make_item(KIND_SEND, 64'h0, 3'd0, 1'b1));
    offer(make_item(KIND_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b0));
    offer(make_item(KIND_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b1));
    offer(make_item(KIND_SEND, 64'h5555_5555_5555_5555, 3'd7, 1'b1));
    offer(make_item(KIND_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b1));
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    // Window is full now, so this send is refused.
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    // Corrupt ack, then a new ack that slides the base by one.
    offer(make_item(KIND_ACK, 64'h0, 3'd0, 1'b0));
    offer(make_item(KIND_ACK, 64'h0, 3'd0, 1'b1));
    // The last slot gets written and the sequence number wraps.
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    offer(make_item(KIND_TIMEOUT, 64'h0, 3'd0, 1'b1));
    // Three duplicates: plain, fast resend, and plain again after the count wraps.
    offer(make_item(KIND_ACK, 64'h0, 3'd0, 1'b1));
    offer(make_item(KIND_ACK, 64'h0, 3'd0, 1'b1));
    offer(make_item(KIND_ACK, 64'h0, 3'd0, 1'b1));
    offer(make_item(KIND_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1));
    // Acking everything empties the window and stops the timer; the next send starts it again.
    offer(make_item(KIND_ACK, 64'h0, 3'd7, 1'b1));
    offer(make_item(KIND_SEND, {$urandom, $urandom}, 3'd0, 1'b1));
    drain();

    // Random phases over several register settings and idle patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(ADDR_WINDOW, 4'(phase_window[p]));
      write_reg(ADDR_SPACE, 4'(phase_space[p]));
      idle_pct  <= phase_idle[p];
      stall_pct <= phase_stall[p];
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      ack_top = (phase_space[p] < 2) ? 1 :
                (phase_space[p] > DEFAULT_MAX_SEQ) ? DEFAULT_MAX_SEQ - 1 : phase_space[p] - 1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) offer(random_item(ack_top));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swsfr_pkg.sv
rtl/swsfr_ctrl.sv
rtl/swsfr_dp.sv
rtl/sliding_window_sender_fast_retx.sv
tb/swsfr_tx_monitor.sv
tb/sliding_window_sender_fast_retx_tb.sv
